// ----- rtl/crtsync_pkg.sv -----
// Shared types, codes and helpers for the CRT sync timebase.
// Used by crtsync_cfg, crtsync_core and crt_sync_timebase_top; no dependencies.
package crtsync_pkg;

    // Default width of the saturating vsync length and spacing counters.
    localparam int SAT_COUNT_BITS_DEF = 20;

    // Request codes.
    localparam logic [2:0] REQ_TICK      = 3'd0;
    localparam logic [2:0] REQ_HSYNC_ON  = 3'd1;
    localparam logic [2:0] REQ_HSYNC_OFF = 3'd2;
    localparam logic [2:0] REQ_VSYNC_ON  = 3'd3;
    localparam logic [2:0] REQ_VSYNC_OFF = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MIN_VSYNC_US  = 3'd0;
    localparam logic [2:0] CFG_MAX_VSYNC_US  = 3'd1;
    localparam logic [2:0] CFG_VSYNC_INT_PCT = 3'd2;
    localparam logic [2:0] CFG_MAX_LINE_US   = 3'd3;
    localparam logic [2:0] CFG_MAX_LINES     = 3'd4;
    localparam logic [2:0] CFG_TST_PER_LINE  = 3'd5;
    localparam logic [2:0] CFG_TST_PER_FRAME = 3'd6;
    localparam logic [2:0] CFG_DROP_SYNC     = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_MIN_VSYNC_US  = 10'd160;
    localparam logic [9:0]  RST_MAX_VSYNC_US  = 10'd400;
    localparam logic [7:0]  RST_VSYNC_INT_PCT = 8'd90;
    localparam logic [9:0]  RST_MAX_LINE_US   = 10'd84;
    localparam logic [9:0]  RST_MAX_LINES     = 10'd320;
    localparam logic [9:0]  RST_TST_PER_LINE  = 10'd207;
    localparam logic [16:0] RST_TST_PER_FRAME = 17'd64584;
    localparam logic [1:0]  RST_DROP_SYNC     = 2'd0;

    // floor(x / 100) for x below 2^30 equals (x * GAP_RECIP) >> 32.
    localparam logic [25:0] GAP_RECIP = 26'd42949673;

    // Cycles after reset or a register write until derived thresholds are valid.
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    localparam logic [14:0] X_MAX = 15'h7FFF;

    typedef enum logic [1:0] {
        VM_OFF       = 2'd0,
        VM_RECEIVED  = 2'd1,
        VM_ACCEPTING = 2'd2,
        VM_EXCEEDED  = 2'd3
    } t_vmode;

    // Thresholds in ticks, derived from the configuration registers.
    typedef struct packed {
        logic [13:0] vmin;
        logic [13:0] vmax;
        logic [13:0] line_to;
        logic [18:0] gap;
        logic [9:0]  max_lines;
        logic [16:0] tpf;
        logic [1:0]  drop;
    } t_thresh;

    // Advance one line, wrapping to zero past the line limit.
    function automatic logic [10:0] next_line(input logic [10:0] y,
                                              input logic [9:0] max_lines);
        logic [10:0] y1;
        y1 = y + 11'd1;
        return (y1 > {1'b0, max_lines}) ? 11'd0 : y1;
    endfunction

endpackage

// ----- rtl/crtsync_cfg.sv -----
// Configuration registers and the tick thresholds derived from them.
// Depends on crtsync_pkg.
module crtsync_cfg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [2:0]            i_index,
    input  logic [16:0]           i_data,
    output crtsync_pkg::t_thresh  o_th,
    output logic                  o_busy
);
    logic [9:0]  r_min_us, r_max_us, r_line_us, r_max_lines, r_tpl;
    logic [7:0]  r_pct;
    logic [16:0] r_tpf;
    logic [1:0]  r_drop;
    logic [1:0]  r_settle;

    logic [13:0] r_vmin, r_vmax, r_line_to;
    logic [24:0] r_gap_prod;
    logic [18:0] r_gap;

    logic [19:0] vmin_prod, vmax_prod, line_prod;
    logic [50:0] gap_recip_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_us    <= crtsync_pkg::RST_MIN_VSYNC_US;
            r_max_us    <= crtsync_pkg::RST_MAX_VSYNC_US;
            r_pct       <= crtsync_pkg::RST_VSYNC_INT_PCT;
            r_line_us   <= crtsync_pkg::RST_MAX_LINE_US;
            r_max_lines <= crtsync_pkg::RST_MAX_LINES;
            r_tpl       <= crtsync_pkg::RST_TST_PER_LINE;
            r_tpf       <= crtsync_pkg::RST_TST_PER_FRAME;
            r_drop      <= crtsync_pkg::RST_DROP_SYNC;
            r_settle    <= crtsync_pkg::SETTLE_CYCLES;
        end else if (i_wr) begin
            r_settle <= crtsync_pkg::SETTLE_CYCLES;
            case (i_index)
                crtsync_pkg::CFG_MIN_VSYNC_US:  r_min_us    <= i_data[9:0];
                crtsync_pkg::CFG_MAX_VSYNC_US:  r_max_us    <= i_data[9:0];
                crtsync_pkg::CFG_VSYNC_INT_PCT: r_pct       <= i_data[7:0];
                crtsync_pkg::CFG_MAX_LINE_US:   r_line_us   <= i_data[9:0];
                crtsync_pkg::CFG_MAX_LINES:     r_max_lines <= i_data[9:0];
                crtsync_pkg::CFG_TST_PER_LINE:  r_tpl       <= i_data[9:0];
                crtsync_pkg::CFG_TST_PER_FRAME: r_tpf       <= i_data;
                crtsync_pkg::CFG_DROP_SYNC:     r_drop      <= i_data[1:0];
                default: ;
            endcase
        end else if (r_settle != 2'd0) begin
            r_settle <= r_settle - 2'd1;
        end
    end

    // Microseconds to ticks: us * ticks_per_line / 64.
    assign vmin_prod = r_min_us * r_tpl;
    assign vmax_prod = r_max_us * r_tpl;
    assign line_prod = r_line_us * r_tpl;
    assign gap_recip_prod = r_gap_prod * crtsync_pkg::GAP_RECIP;

    // Two register stages: products first, then the divide by 100 of the spacing.
    always_ff @(posedge i_clk) begin
        r_vmin     <= vmin_prod[19:6];
        r_vmax     <= vmax_prod[19:6];
        r_line_to  <= line_prod[19:6];
        r_gap_prod <= r_tpf * r_pct;
        r_gap      <= gap_recip_prod[50:32];
    end

    assign o_th.vmin      = r_vmin;
    assign o_th.vmax      = r_vmax;
    assign o_th.line_to   = r_line_to;
    assign o_th.gap       = r_gap;
    assign o_th.max_lines = r_max_lines;
    assign o_th.tpf       = r_tpf;
    assign o_th.drop      = r_drop;
    assign o_busy         = (r_settle != 2'd0);

endmodule

// ----- rtl/crtsync_core.sv -----
// Timebase state and its combinational update for one request.
// The state registers double as the result register. Depends on crtsync_pkg.
module crtsync_core #(
    parameter int SAT_COUNT_BITS = crtsync_pkg::SAT_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [2:0]            i_req_type,
    input  logic [7:0]            i_tick_len,
    input  crtsync_pkg::t_thresh  i_th,
    output logic [14:0]           o_beam_x,
    output logic [10:0]           o_beam_y,
    output logic [16:0]           o_frame_time,
    output logic [1:0]            o_vsync_state,
    output logic                  o_hsync_level,
    output logic                  o_vsync_accepted,
    output logic [1:0]            o_lines_advanced
);
    localparam logic [SAT_COUNT_BITS-1:0] SAT_MAX = {SAT_COUNT_BITS{1'b1}};

    logic [14:0]               r_x, n_x;
    logic [10:0]               r_y, n_y;
    logic [16:0]               r_frame, n_frame;
    crtsync_pkg::t_vmode       r_mode, n_mode;
    logic [SAT_COUNT_BITS-1:0] r_vlen, n_vlen, r_since, n_since;
    logic                      r_hs_on, n_hs_on, r_hs_pend, n_hs_pend;
    logic                      r_acc, n_acc;
    logic [1:0]                r_lines, n_lines;

    logic [15:0]               x_sum;
    logic [SAT_COUNT_BITS:0]   vl_sum, sv_sum;
    logic [SAT_COUNT_BITS-1:0] since_base;
    logic [17:0]               f_sum, f_wrap;

    assign x_sum = {1'b0, r_x} + 16'(i_tick_len);
    assign vl_sum = {1'b0, r_vlen} + (SAT_COUNT_BITS + 1)'(i_tick_len);
    assign f_sum = {1'b0, r_frame} + 18'(i_tick_len);
    assign f_wrap = (f_sum >= {1'b0, i_th.tpf}) ? (f_sum - {1'b0, i_th.tpf}) : f_sum;
    assign sv_sum = {1'b0, since_base} + (SAT_COUNT_BITS + 1)'(i_tick_len);

    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_frame   = r_frame;
        n_mode    = r_mode;
        n_vlen    = r_vlen;
        n_since   = r_since;
        n_hs_on   = r_hs_on;
        n_hs_pend = r_hs_pend;
        n_acc     = 1'b0;
        n_lines   = 2'd0;
        since_base = r_since;
        case (i_req_type)
            crtsync_pkg::REQ_TICK: begin
                if (r_mode != crtsync_pkg::VM_ACCEPTING) begin
                    n_x = x_sum[15] ? crtsync_pkg::X_MAX : x_sum[14:0];
                end
                if (r_mode != crtsync_pkg::VM_OFF) begin
                    n_vlen = vl_sum[SAT_COUNT_BITS] ? SAT_MAX
                                                    : vl_sum[SAT_COUNT_BITS-1:0];
                    if (r_mode == crtsync_pkg::VM_RECEIVED) begin
                        // The spacing may be wider than a narrow counter, so compare at 32 bits.
                        if (n_vlen >= SAT_COUNT_BITS'(i_th.vmin) &&
                            n_vlen < SAT_COUNT_BITS'(i_th.vmax) &&
                            32'(r_since) >= 32'(i_th.gap)) begin
                            since_base = '0;
                            n_mode     = crtsync_pkg::VM_ACCEPTING;
                            n_acc      = 1'b1;
                        end
                    end else if (r_mode == crtsync_pkg::VM_ACCEPTING) begin
                        n_y = 11'd0;
                        if (n_vlen > SAT_COUNT_BITS'(i_th.vmax)) begin
                            n_mode = crtsync_pkg::VM_EXCEEDED;
                        end
                    end
                end else begin
                    if (r_hs_on) begin
                        n_x = 15'd0;
                    end
                    if (r_hs_pend) begin
                        n_hs_pend = 1'b0;
                        n_y       = crtsync_pkg::next_line(n_y, i_th.max_lines);
                        n_x       = 15'd0;
                        n_lines   = 2'd1;
                    end
                end
                // Hsync timeout, suppressed while the beam is held by vsync.
                if (n_x >= {1'b0, i_th.line_to} && n_mode != crtsync_pkg::VM_ACCEPTING) begin
                    n_y     = crtsync_pkg::next_line(n_y, i_th.max_lines);
                    n_x     = 15'd0;
                    n_lines = n_lines + 2'd1;
                end
                n_frame = f_wrap[16:0];
                n_since = sv_sum[SAT_COUNT_BITS] ? SAT_MAX : sv_sum[SAT_COUNT_BITS-1:0];
            end
            crtsync_pkg::REQ_HSYNC_ON: begin
                if (!i_th.drop[0] && !r_hs_on) begin
                    n_hs_on   = 1'b1;
                    n_hs_pend = 1'b1;
                end
            end
            crtsync_pkg::REQ_HSYNC_OFF: begin
                n_hs_on = 1'b0;
            end
            crtsync_pkg::REQ_VSYNC_ON: begin
                if (!i_th.drop[1] && r_mode == crtsync_pkg::VM_OFF) begin
                    n_mode = crtsync_pkg::VM_RECEIVED;
                    n_vlen = '0;
                end
            end
            crtsync_pkg::REQ_VSYNC_OFF: begin
                n_mode = crtsync_pkg::VM_OFF;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x       <= '0;
            r_y       <= '0;
            r_frame   <= '0;
            r_mode    <= crtsync_pkg::VM_OFF;
            r_vlen    <= '0;
            r_since   <= '0;
            r_hs_on   <= 1'b0;
            r_hs_pend <= 1'b0;
            r_acc     <= 1'b0;
            r_lines   <= 2'd0;
        end else if (i_go) begin
            r_x       <= n_x;
            r_y       <= n_y;
            r_frame   <= n_frame;
            r_mode    <= n_mode;
            r_vlen    <= n_vlen;
            r_since   <= n_since;
            r_hs_on   <= n_hs_on;
            r_hs_pend <= n_hs_pend;
            r_acc     <= n_acc;
            r_lines   <= n_lines;
        end
    end

    assign o_beam_x         = r_x;
    assign o_beam_y         = r_y;
    assign o_frame_time     = r_frame;
    assign o_vsync_state    = r_mode;
    assign o_hsync_level    = r_hs_on;
    assign o_vsync_accepted = r_acc;
    assign o_lines_advanced = r_lines;

endmodule

// ----- rtl/crt_sync_timebase_top.sv -----
// Top level of the CRT sync timebase: input register, handshakes, and the
// configuration and core blocks. Depends on crtsync_pkg, crtsync_cfg, crtsync_core.
//
//  Channel | Signals                                  | Direction
//  --------+------------------------------------------+----------
//  request | i_in_valid, o_in_ready, i_req_type,      | in
//          | i_tick_len                               |
//  result  | o_out_valid, i_out_ready, o_beam_x ...   | out
//          | o_lines_advanced                         |
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index,   | in
//          | i_cfg_data                               |
//
// One request per cycle is sustained while results are taken and the thresholds are not
// being recomputed; the transaction loads the input register, and the held request
// then updates the state registers, which hold its result, once the result slot is free.
// The whole state update is combinational from the input register.
// After reset and after every configuration write the request channel holds
// ready low while the tick thresholds are recomputed.
// A stalled result holds the state; the input register still takes one request.
module crt_sync_timebase_top #(
    parameter int SAT_COUNT_BITS = crtsync_pkg::SAT_COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [7:0]  i_tick_len,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [14:0] o_beam_x,
    output logic [10:0] o_beam_y,
    output logic [16:0] o_frame_time,
    output logic [1:0]  o_vsync_state,
    output logic        o_hsync_level,
    output logic        o_vsync_accepted,
    output logic [1:0]  o_lines_advanced,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    crtsync_pkg::t_thresh th;
    logic       cfg_busy;
    logic       go;
    logic       r_in_valid;
    logic [2:0] r_req_type;
    logic [7:0] r_tick_len;
    logic       r_out_valid;

    assign o_cfg_ready = 1'b1;

    // The held request moves into the state update when the result slot frees.
    assign go         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !cfg_busy && (!r_in_valid || go);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (go) begin
                r_in_valid <= 1'b0;
            end
            if (go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req_type <= i_req_type;
            r_tick_len <= i_tick_len;
        end
    end

    crtsync_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_th    (th),
        .o_busy  (cfg_busy)
    );

    crtsync_core #(
        .SAT_COUNT_BITS (SAT_COUNT_BITS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_go             (go),
        .i_req_type       (r_req_type),
        .i_tick_len       (r_tick_len),
        .i_th             (th),
        .o_beam_x         (o_beam_x),
        .o_beam_y         (o_beam_y),
        .o_frame_time     (o_frame_time),
        .o_vsync_state    (o_vsync_state),
        .o_hsync_level    (o_hsync_level),
        .o_vsync_accepted (o_vsync_accepted),
        .o_lines_advanced (o_lines_advanced)
    );

    assign o_out_valid = r_out_valid;

endmodule

// ----- sim/tb_crt_sync_timebase_top.sv -----
`timescale 1ns / 100ps
// Testbench for crt_sync_timebase_top: sends tick and sync requests, predicts each
// beam result with its own model of the timebase, and checks the results in order.
// Depends on crtsync_pkg and the RTL below crt_sync_timebase_top.
module tb_crt_sync_timebase_top;

    localparam int          SAT_BITS       = crtsync_pkg::SAT_COUNT_BITS_DEF;
    localparam int unsigned SAT_MAX        = (1 << SAT_BITS) - 1;
    localparam int unsigned X_LIMIT        = 32767;
    localparam int unsigned LINE_US        = 64;
    localparam int unsigned PCT_SCALE      = 100;
    localparam int          IDLE_PCT       = 21;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_REPORTS    = 10;
    localparam int          TAIL_CYCLES    = 8;
    localparam int          PHASE_ITEMS    = 90;

    typedef struct packed {
        logic [14:0] x;
        logic [10:0] y;
        logic [16:0] ft;
        logic [1:0]  vs;
        logic        hs;
        logic        acc;
        logic [1:0]  lines;
    } t_beam_state;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic [2:0]  i_req_type       = crtsync_pkg::REQ_TICK;
    logic [7:0]  i_tick_len       = 8'h00;
    logic        i_out_ready      = 1'b0;
    logic        i_cfg_valid      = 1'b0;
    logic [2:0]  i_cfg_index      = crtsync_pkg::CFG_MIN_VSYNC_US;
    logic [16:0] i_cfg_data       = 17'h0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [14:0] o_beam_x;
    logic [10:0] o_beam_y;
    logic [16:0] o_frame_time;
    logic [1:0]  o_vsync_state;
    logic        o_hsync_level;
    logic        o_vsync_accepted;
    logic [1:0]  o_lines_advanced;
    logic        o_cfg_ready;

    // Predicted configuration and timebase state.
    int unsigned cfg_min_us, cfg_max_us, cfg_pct, cfg_line_us;
    int unsigned cfg_lines, cfg_tpl, cfg_tpf;
    logic [1:0]  cfg_drop;
    int unsigned pr_x, pr_frame, pr_vlen, pr_since;
    logic [10:0] pr_y;
    crtsync_pkg::t_vmode pr_mode;
    logic        pr_hs_level, pr_hs_pend;

    t_beam_state beam_expected[$];
    logic        steady_flow     = 1'b0;
    int          items_sent      = 0;
    int          items_accepted  = 0;
    int          results_seen    = 0;
    int          vsync_locks     = 0;
    int          lines_total     = 0;
    int          regs_written    = 0;
    int          beam_mismatches = 0;
    int          quiet_cycles    = 0;

    crt_sync_timebase_top dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int unsigned us_ticks(input int unsigned us);
        return us * cfg_tpl / LINE_US;
    endfunction

    function automatic int unsigned sat_count(input int unsigned v);
        return (v > SAT_MAX) ? SAT_MAX : v;
    endfunction

    function automatic void advance_line();
        pr_y = pr_y + 11'd1;
        if (pr_y > cfg_lines) pr_y = '0;
    endfunction

    function automatic void reset_timebase_model();
        cfg_min_us  = crtsync_pkg::RST_MIN_VSYNC_US;
        cfg_max_us  = crtsync_pkg::RST_MAX_VSYNC_US;
        cfg_pct     = crtsync_pkg::RST_VSYNC_INT_PCT;
        cfg_line_us = crtsync_pkg::RST_MAX_LINE_US;
        cfg_lines   = crtsync_pkg::RST_MAX_LINES;
        cfg_tpl     = crtsync_pkg::RST_TST_PER_LINE;
        cfg_tpf     = crtsync_pkg::RST_TST_PER_FRAME;
        cfg_drop    = crtsync_pkg::RST_DROP_SYNC;
        pr_x        = 0;
        pr_y        = '0;
        pr_frame    = 0;
        pr_mode     = crtsync_pkg::VM_OFF;
        pr_vlen     = 0;
        pr_since    = 0;
        pr_hs_level = 1'b0;
        pr_hs_pend  = 1'b0;
    endfunction

    function automatic void store_register(input logic [2:0] idx, input logic [16:0] data);
        case (idx)
            crtsync_pkg::CFG_MIN_VSYNC_US:  cfg_min_us  = data[9:0];
            crtsync_pkg::CFG_MAX_VSYNC_US:  cfg_max_us  = data[9:0];
            crtsync_pkg::CFG_VSYNC_INT_PCT: cfg_pct     = data[7:0];
            crtsync_pkg::CFG_MAX_LINE_US:   cfg_line_us = data[9:0];
            crtsync_pkg::CFG_MAX_LINES:     cfg_lines   = data[9:0];
            crtsync_pkg::CFG_TST_PER_LINE:  cfg_tpl     = data[9:0];
            crtsync_pkg::CFG_TST_PER_FRAME: cfg_tpf     = data;
            default:                        cfg_drop    = data[1:0];
        endcase
    endfunction

    // Applies one request to the predicted state and returns the beam result it yields.
    function automatic t_beam_state step_timebase(input logic [2:0] req, input logic [7:0] len);
        t_beam_state r;
        int unsigned vmax_t, gap_t;
        logic        took;
        logic [1:0]  adv;
        took = 1'b0;
        adv  = 2'd0;
        case (req)
            crtsync_pkg::REQ_TICK: begin
                vmax_t = us_ticks(cfg_max_us);
                if (pr_mode != crtsync_pkg::VM_ACCEPTING) begin
                    pr_x = pr_x + len;
                    if (pr_x > X_LIMIT) pr_x = X_LIMIT;
                end
                if (pr_mode != crtsync_pkg::VM_OFF) begin
                    pr_vlen = sat_count(pr_vlen + len);
                    if (pr_mode == crtsync_pkg::VM_RECEIVED) begin
                        gap_t = cfg_tpf * cfg_pct / PCT_SCALE;
                        if (pr_vlen >= us_ticks(cfg_min_us) && pr_vlen < vmax_t &&
                            pr_since >= gap_t) begin
                            pr_since = 0;
                            pr_mode  = crtsync_pkg::VM_ACCEPTING;
                            took     = 1'b1;
                        end
                    end else if (pr_mode == crtsync_pkg::VM_ACCEPTING) begin
                        pr_y = '0;
                        if (pr_vlen > vmax_t) pr_mode = crtsync_pkg::VM_EXCEEDED;
                    end
                end else begin
                    if (pr_hs_level) pr_x = 0;
                    if (pr_hs_pend) begin
                        pr_hs_pend = 1'b0;
                        advance_line();
                        pr_x = 0;
                        adv++;
                    end
                end
                // Hsync timeout; a zero timeout fires on every tick outside an accepted vsync.
                if (pr_x >= us_ticks(cfg_line_us) && pr_mode != crtsync_pkg::VM_ACCEPTING) begin
                    advance_line();
                    pr_x = 0;
                    adv++;
                end
                // Only one wrap is taken, even after the frame length was shortened.
                pr_frame = pr_frame + len;
                if (pr_frame >= cfg_tpf) pr_frame = pr_frame - cfg_tpf;
                pr_frame = pr_frame & 32'h1FFFF;
                pr_since = sat_count(pr_since + len);
            end
            crtsync_pkg::REQ_HSYNC_ON: begin
                if (!cfg_drop[0] && !pr_hs_level) begin
                    pr_hs_level = 1'b1;
                    pr_hs_pend  = 1'b1;
                end
            end
            crtsync_pkg::REQ_HSYNC_OFF: pr_hs_level = 1'b0;
            crtsync_pkg::REQ_VSYNC_ON: begin
                if (!cfg_drop[1] && pr_mode == crtsync_pkg::VM_OFF) begin
                    pr_mode = crtsync_pkg::VM_RECEIVED;
                    pr_vlen = 0;
                end
            end
            crtsync_pkg::REQ_VSYNC_OFF: pr_mode = crtsync_pkg::VM_OFF;
            default: ;
        endcase
        r.x     = pr_x[14:0];
        r.y     = pr_y;
        r.ft    = pr_frame[16:0];
        r.vs    = pr_mode;
        r.hs    = pr_hs_level;
        r.acc   = took;
        r.lines = adv;
        return r;
    endfunction

    function automatic string diff_fields(input t_beam_state want, input t_beam_state got);
        string s;
        s = "";
        if (got.x !== want.x)         s = {s, " beam_x"};
        if (got.y !== want.y)         s = {s, " beam_y"};
        if (got.ft !== want.ft)       s = {s, " frame_time"};
        if (got.vs !== want.vs)       s = {s, " vsync_state"};
        if (got.hs !== want.hs)       s = {s, " hsync_level"};
        if (got.acc !== want.acc)     s = {s, " vsync_accepted"};
        if (got.lines !== want.lines) s = {s, " lines_advanced"};
        return s;
    endfunction

    task automatic report_fault(input string what, input t_beam_state want,
                                input t_beam_state got);
        beam_mismatches++;
        if (beam_mismatches <= MAX_REPORTS) begin
            $display("[%0t] beam result wrong:%s", $time, what);
            $display("    expected x=%0d y=%0d ft=%0d vs=%0d hs=%0b acc=%0b lines=%0d",
                     want.x, want.y, want.ft, want.vs, want.hs, want.acc, want.lines);
            $display("    actual   x=%0d y=%0d ft=%0d vs=%0d hs=%0b acc=%0b lines=%0d",
                     got.x, got.y, got.ft, got.vs, got.hs, got.acc, got.lines);
        end
    endtask

    // Register writes and request transactions update the prediction in acceptance order.
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            store_register(i_cfg_index, i_cfg_data);
            regs_written++;
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            beam_expected.push_back(step_timebase(i_req_type, i_tick_len));
            items_accepted++;
        end
    end

    always @(posedge i_clk) begin
        t_beam_state got;
        t_beam_state want;
        string       diffs;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_beam_x, o_beam_y, o_frame_time, o_vsync_state, o_hsync_level,
                   o_vsync_accepted, o_lines_advanced};
            results_seen++;
            vsync_locks += got.acc;
            lines_total += got.lines;
            if (beam_expected.size() == 0) begin
                report_fault(" result with nothing outstanding", got, got);
            end else begin
                want  = beam_expected.pop_front();
                diffs = diff_fields(want, got);
                if (diffs != "") report_fault(diffs, want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Called just after a rising edge; returns at the edge that accepts the request.
    task automatic send_request(input logic [2:0] req, input logic [7:0] len);
        while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_tick_len <= len;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic send_tick(input int unsigned len);
        send_request(crtsync_pkg::REQ_TICK, 8'(len));
    endtask

    task automatic send_sync(input logic [2:0] req);
        send_request(req, 8'($urandom_range(255)));
    endtask

    task automatic send_random_request();
        logic [2:0] req;
        logic [7:0] len;
        if ($urandom_range(99) < 50)
            req = crtsync_pkg::REQ_TICK;
        else
            req = 3'($urandom_range(crtsync_pkg::REQ_VSYNC_OFF, crtsync_pkg::REQ_HSYNC_ON));
        case ($urandom_range(9))
            0:       len = 8'h00;
            1:       len = 8'hFF;
            default: len = 8'($urandom_range(255));
        endcase
        send_request(req, len);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (beam_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input int unsigned val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= 17'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Registers change only once every outstanding result has come back.
    task automatic load_settings(input int unsigned min_us, input int unsigned max_us,
                                 input int unsigned pct, input int unsigned line_us,
                                 input int unsigned lines, input int unsigned tpl,
                                 input int unsigned tpf, input int unsigned drop);
        wait_results_drained();
        write_register(crtsync_pkg::CFG_MIN_VSYNC_US, min_us);
        write_register(crtsync_pkg::CFG_MAX_VSYNC_US, max_us);
        write_register(crtsync_pkg::CFG_VSYNC_INT_PCT, pct);
        write_register(crtsync_pkg::CFG_MAX_LINE_US, line_us);
        write_register(crtsync_pkg::CFG_MAX_LINES, lines);
        write_register(crtsync_pkg::CFG_TST_PER_LINE, tpl);
        write_register(crtsync_pkg::CFG_TST_PER_FRAME, tpf);
        write_register(crtsync_pkg::CFG_DROP_SYNC, drop);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_values();
        int r;
        send_tick(0);
        send_tick(255);
        send_sync(crtsync_pkg::REQ_HSYNC_ON);
        send_sync(crtsync_pkg::REQ_HSYNC_ON);
        send_tick(10);
        send_sync(crtsync_pkg::REQ_HSYNC_OFF);
        send_tick(255);
        send_tick(20);
        for (r = int'(crtsync_pkg::REQ_VSYNC_OFF) + 1; r < 8; r++) send_request(3'(r), 8'hFF);
        send_sync(crtsync_pkg::REQ_VSYNC_ON);
        send_sync(crtsync_pkg::REQ_VSYNC_ON);
        // The pending hsync waits until vsync is off again.
        send_sync(crtsync_pkg::REQ_HSYNC_ON);
        send_tick(255);
        send_tick(255);
        send_tick(100);
        send_sync(crtsync_pkg::REQ_VSYNC_OFF);
        send_tick(1);
    endtask

    task automatic test_zero_line_timeout();
        load_settings(0, 1023, 0, 1, 1, 1, 1, 0);
        send_tick(0);
        send_tick(0);
        send_sync(crtsync_pkg::REQ_HSYNC_ON);
        send_tick(3);
        send_sync(crtsync_pkg::REQ_HSYNC_OFF);
        send_sync(crtsync_pkg::REQ_VSYNC_ON);
        send_tick(0);
        send_tick(5);
        send_tick(20);
        send_sync(crtsync_pkg::REQ_VSYNC_OFF);
        send_tick(255);
    endtask

    task automatic test_setting_extremes();
        int s;
        for (s = 0; s < 4; s++) begin
            case (s)
                0:       load_settings(0, 0, 0, 1, 1, 1, 1, 0);
                1:       load_settings(1023, 1023, 200, 1023, 1023, 1023, 131071, 3);
                2:       load_settings(0, 1023, 0, 20, 4, 64, 200, 1);
                default: load_settings(5, 60, 50, 30, 3, 64, 300, 2);
            endcase
            repeat (30) send_random_request();
        end
    endtask

    // Shortening the frame below the current position takes only a single wrap,
    // and a zero frame length never wraps.
    task automatic test_frame_shortening();
        load_settings(0, 1023, 200, 1023, 1023, 1023, 300, 0);
        steady_flow = 1'b1;
        send_tick(255);
        send_tick(40);
        load_settings(0, 1023, 200, 1023, 1023, 1023, 100, 0);
        send_tick(255);
        send_tick(255);
        send_sync(crtsync_pkg::REQ_VSYNC_ON);
        send_tick(0);
        load_settings(0, 1023, 200, 1023, 1023, 1023, 0, 0);
        send_tick(255);
        send_tick(255);
        send_sync(crtsync_pkg::REQ_VSYNC_OFF);
        send_tick(1);
        steady_flow = 1'b0;
    endtask

    task automatic send_frame(input int unsigned lines_per);
        int unsigned vmin_t, vmax_t, step, target, pulse, k, n;
        vmin_t = us_ticks(cfg_min_us);
        vmax_t = us_ticks(cfg_max_us);
        step   = (vmax_t > vmin_t) ? (vmax_t - vmin_t) / 2 : 1;
        if (step < 1) step = 1;
        if (step > 40) step = 40;
        if ($urandom_range(99) < 85)
            target = $urandom_range(vmax_t, vmin_t);
        else
            target = $urandom_range(vmax_t + 40, 0);
        send_sync(crtsync_pkg::REQ_VSYNC_ON);
        pulse = 0;
        while (pulse < target) begin
            k = $urandom_range(step, 1);
            send_tick(k);
            pulse += k;
        end
        if ($urandom_range(99) < 20) send_tick($urandom_range(255));
        send_sync(crtsync_pkg::REQ_VSYNC_OFF);
        n = $urandom_range(lines_per + 3, (lines_per > 3) ? lines_per - 3 : 1);
        repeat (n) begin
            // Now and then a line has no hsync and ends on the timeout.
            if ($urandom_range(99) < 90) begin
                send_sync(crtsync_pkg::REQ_HSYNC_ON);
                send_tick($urandom_range(12));
                send_sync(crtsync_pkg::REQ_HSYNC_OFF);
            end
            send_tick($urandom_range(cfg_tpl, cfg_tpl / 2));
            send_tick($urandom_range(cfg_tpl / 2));
        end
    endtask

    task automatic test_random_frames();
        int          phase, start;
        int unsigned tpl, lines_per, min_us, max_us, lines, drop;
        logic        paused;
        for (phase = 0; phase < 5; phase++) begin
            tpl       = $urandom_range(64, 24);
            lines_per = $urandom_range(16, 6);
            min_us    = $urandom_range(40, 2);
            max_us    = min_us + $urandom_range(160, 8);
            if ($urandom_range(99) < 25)
                lines = $urandom_range(lines_per, 2);
            else
                lines = lines_per + $urandom_range(8);
            drop = ($urandom_range(99) < 80) ? 0 : $urandom_range(3, 1);
            load_settings(min_us, max_us, $urandom_range(110, 60), $urandom_range(100, 64),
                          lines, tpl, tpl * lines_per + $urandom_range(tpl), drop);
            steady_flow = (phase == 1);
            paused      = 1'b0;
            start       = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 80)
                    send_frame(lines_per);
                else
                    repeat ($urandom_range(12, 4)) send_random_request();
                if (!paused && items_sent - start >= PHASE_ITEMS / 2) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        reset_timebase_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_zero_line_timeout();
        test_setting_extremes();
        test_frame_shortening();
        test_random_frames();
        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (beam_expected.size() != 0) begin
            $display("%0d predicted results never arrived", beam_expected.size());
            beam_mismatches += beam_expected.size();
        end
        $display("Run covered %0d requests and %0d checked results, %0d register writes.",
                 items_accepted, results_seen, regs_written);
        $display("Saw %0d vsync locks and %0d line advances; %0d bad results.",
                 vsync_locks, lines_total, beam_mismatches);
        if (beam_mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/crtsync_pkg.sv
rtl/crtsync_cfg.sv
rtl/crtsync_core.sv
rtl/crt_sync_timebase_top.sv
sim/tb_crt_sync_timebase_top.sv
